// ----- design/assert_macros.svh -----
// Shared assertion macros. Clock and reset are taken as clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TMDF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TMDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tmdf_pkg.sv -----
package tmdf_pkg;

	// Field widths
	localparam int CH_W   = 3;
	localparam int SMP_W  = 16;
	localparam int LVL_W  = 10;
	localparam int CIDX_W = 2;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_DISTANCE_LIMIT = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LEVEL_OFFSET   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_LEVEL_CEILING  = 2'd2;
	localparam logic [CIDX_W-1:0] REG_DEADBAND       = 2'd3;

	// Register reset values
	localparam logic [SMP_W-1:0] RST_DISTANCE_LIMIT = 16'd1000;
	localparam logic [LVL_W-1:0] RST_LEVEL_OFFSET   = 10'd100;
	localparam logic [LVL_W-1:0] RST_LEVEL_CEILING  = 10'd500;
	localparam logic [LVL_W-1:0] RST_DEADBAND       = 10'd3;

	typedef struct packed {
		logic [SMP_W-1:0] distance_limit;
		logic [LVL_W-1:0] level_offset;
		logic [LVL_W-1:0] level_ceiling;
		logic [LVL_W-1:0] deadband;
	} tmdf_cfg_t;

	// Trimmed mean of one burst, on its way to the hold stage
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [SMP_W-1:0] mean;
	} tmdf_mean_t;

	// One result beat
	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] held_level;
		logic             changed;
	} tmdf_res_t;

endpackage

// ----- design/tmdf_ifs.sv -----
// Sample channel
interface tmdf_in_if import tmdf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  channel;
	logic [SMP_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

// Result channel
interface tmdf_out_if import tmdf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_channel;
	logic [LVL_W-1:0] level;
	logic [LVL_W-1:0] held_level;
	logic             changed;

	modport source (output valid, output out_channel, output level, output held_level,
		output changed, input ready);
	modport sink (input valid, input out_channel, input level, input held_level,
		input changed, output ready);
endinterface

// ----- design/tmdf_burst.sv -----
// Input register, burst accumulator and trimmed-sum register
module tmdf_burst import tmdf_pkg::*; #(
	parameter int SAMPLES = 7,
	parameter int SUM_W   = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SMP_W-1:0] distance_limit,
	input  logic             load1,
	input  logic [CH_W-1:0]  ch_in,
	input  logic [SMP_W-1:0] smp_in,
	input  logic             mv1,
	output logic             last,
	output logic [CH_W-1:0]  ch_s2,
	output logic [SUM_W-1:0] trim_s2
);

	localparam int CNT_W = $clog2(SAMPLES + 1);

	logic [CH_W-1:0]  ch_s1;
	logic [SMP_W-1:0] smp_s1;
	logic [SUM_W-1:0] sum_q;
	logic [SMP_W-1:0] min_q;
	logic [SMP_W-1:0] max_q;
	logic [CNT_W-1:0] cnt_q;

	logic [SMP_W-1:0] sat;
	logic [SUM_W-1:0] sum_n;
	logic [SMP_W-1:0] min_n;
	logic [SMP_W-1:0] max_n;

	// Input register
	always_ff @(posedge clk) begin
		if (load1) begin
			ch_s1  <= ch_in;
			smp_s1 <= smp_in;
		end
	end

	// Saturate and fold the sample into the running figures
	always_comb begin
		sat   = (smp_s1 > distance_limit) ? distance_limit : smp_s1;
		sum_n = sum_q + SUM_W'(sat);
		min_n = (sat < min_q) ? sat : min_q;
		max_n = (sat > max_q) ? sat : max_q;
		last  = (cnt_q == CNT_W'(SAMPLES - 1));
	end

	// Burst state; restarts after the closing sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
			cnt_q <= '0;
		end else if (mv1) begin
			if (last) begin
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_n;
				min_q <= min_n;
				max_q <= max_n;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Trimmed sum: extremes dropped
	always_ff @(posedge clk) begin
		if (mv1 && last) begin
			ch_s2   <= ch_s1;
			trim_s2 <= sum_n - SUM_W'(min_n) - SUM_W'(max_n);
		end
	end

endmodule

// ----- design/tmdf_div.sv -----
// Division of the trimmed sum by SAMPLES-2 via reciprocal multiply
module tmdf_div import tmdf_pkg::*; #(
	parameter int SAMPLES = 7,
	parameter int SUM_W   = 19
) (
	input  logic             clk,
	input  logic             mv2,
	input  logic [CH_W-1:0]  ch_s2,
	input  logic [SUM_W-1:0] trim_s2,
	output tmdf_mean_t       mean_s3
);

	// floor(n/D) == (n*M) >> SH for all n < 2**SUM_W, M = ceil(2**SH / D)
	localparam int DIV    = SAMPLES - 2;
	localparam int LOG_D  = (DIV > 1) ? $clog2(DIV) : 0;
	localparam int SH     = SUM_W + LOG_D;
	localparam int M_W    = SUM_W + 1;
	localparam longint unsigned RECIP_L = ((longint'(1) << SH) + DIV - 1) / DIV;
	localparam logic [M_W-1:0]  RECIP   = M_W'(RECIP_L);

	logic [SUM_W+M_W-1:0] prod;

	assign prod = (SUM_W + M_W)'(trim_s2) * (SUM_W + M_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (mv2) begin
			mean_s3.ch   <= ch_s2;
			mean_s3.mean <= prod[SH +: SMP_W];
		end
	end

endmodule

// ----- design/tmdf_hold.sv -----
// Offset, ceiling, deadband hold per channel and result register
module tmdf_hold import tmdf_pkg::*; #(
	parameter int CHANNELS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tmdf_cfg_t  cfg,
	input  logic       mv3,
	input  tmdf_mean_t mean_s3,
	output tmdf_res_t  res_q
);

	localparam int HIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [LVL_W-1:0]  held_q [CHANNELS];
	logic [HIDX_W-1:0] idx;
	logic [SMP_W-1:0]  corr;
	logic [LVL_W-1:0]  lvl;
	logic [LVL_W-1:0]  held;
	logic [LVL_W-1:0]  diff;
	logic              chg;

	// Level after offset (floored at zero) and ceiling
	always_comb begin
		idx  = HIDX_W'(mean_s3.ch);
		corr = (mean_s3.mean > SMP_W'(cfg.level_offset))
			? mean_s3.mean - SMP_W'(cfg.level_offset) : '0;
		lvl  = (corr > SMP_W'(cfg.level_ceiling)) ? cfg.level_ceiling : corr[LVL_W-1:0];
		held = held_q[idx];
		diff = (held > lvl) ? held - lvl : lvl - held;
		chg  = (diff > cfg.deadband);
	end

	// Held values per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				held_q[i] <= '0;
			end
		end else if (mv3 && chg) begin
			held_q[idx] <= lvl;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (mv3) begin
			res_q.out_channel <= mean_s3.ch;
			res_q.level       <= lvl;
			res_q.held_level  <= chg ? lvl : held;
			res_q.changed     <= chg;
		end
	end

endmodule

// ----- design/trimmed_mean_deadband_filter_unit.sv -----
// Trimmed-mean level filter. One sample beat can be taken every cycle unless
// back-pressure holds in.ready low; the burst accumulator updates its sum,
// minimum, maximum and count at once, which sets that rate. Samples with a
// channel of CHANNELS or more are dropped. Every SAMPLES-th kept sample closes
// a burst and yields one result beat through the input register, trimmed-sum
// register, mean register and result register. A waiting result does not
// stop sample intake until the three stages behind it are full.
// Configuration writes must be made while the block is empty.
`include "assert_macros.svh"

module trimmed_mean_deadband_filter_unit import tmdf_pkg::*; #(
	parameter int CHANNELS = 5,
	parameter int SAMPLES  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [SMP_W-1:0]  cfg_wdata,
	tmdf_in_if.sink           in,
	tmdf_out_if.source        out
);

	localparam int SUM_W = $clog2(SAMPLES * ((1 << SMP_W) - 1) + 1);
	localparam logic [CH_W+1:0] CH_LIM = (CH_W + 2)'(CHANNELS);

	tmdf_cfg_t        cfg_q;
	logic             v1_q, v2_q, v3_q, out_v_q;
	logic             free1, free2, free3, free_o;
	logic             acc, mv1, mv2, mv3;
	logic             burst_last;
	logic [CH_W-1:0]  ch_s2;
	logic [SUM_W-1:0] trim_s2;
	tmdf_mean_t       mean_s3;
	tmdf_res_t        res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_limit <= RST_DISTANCE_LIMIT;
			cfg_q.level_offset   <= RST_LEVEL_OFFSET;
			cfg_q.level_ceiling  <= RST_LEVEL_CEILING;
			cfg_q.deadband       <= RST_DEADBAND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISTANCE_LIMIT: cfg_q.distance_limit <= cfg_wdata;
				REG_LEVEL_OFFSET:   cfg_q.level_offset   <= cfg_wdata[LVL_W-1:0];
				REG_LEVEL_CEILING:  cfg_q.level_ceiling  <= cfg_wdata[LVL_W-1:0];
				REG_DEADBAND:       cfg_q.deadband       <= cfg_wdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage flow: a stage moves on when the one after it is empty or moving
	assign free_o   = !out_v_q || out.ready;
	assign free3    = !v3_q || free_o;
	assign free2    = !v2_q || free3;
	assign free1    = !v1_q || free2;
	assign in.ready = free1;
	assign acc      = in.valid && free1;
	assign mv1      = v1_q && free2;
	assign mv2      = v2_q && free3;
	assign mv3      = v3_q && free_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free1) v1_q <= acc && ({2'b00, in.channel} < CH_LIM);
			if (free2) v2_q <= mv1 && burst_last;
			if (free3) v3_q <= v2_q;
			if (free_o) out_v_q <= v3_q;
		end
	end

	tmdf_burst #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_burst (
		.clk            (clk),
		.arst_n         (arst_n),
		.distance_limit (cfg_q.distance_limit),
		.load1          (acc),
		.ch_in          (in.channel),
		.smp_in         (in.sample),
		.mv1            (mv1),
		.last           (burst_last),
		.ch_s2          (ch_s2),
		.trim_s2        (trim_s2)
	);

	tmdf_div #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_div (
		.clk     (clk),
		.mv2     (mv2),
		.ch_s2   (ch_s2),
		.trim_s2 (trim_s2),
		.mean_s3 (mean_s3)
	);

	tmdf_hold #(.CHANNELS(CHANNELS)) u_hold (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.mv3     (mv3),
		.mean_s3 (mean_s3),
		.res_q   (res_q)
	);

	// Result beat
	assign out.valid       = out_v_q;
	assign out.out_channel = res_q.out_channel;
	assign out.level       = res_q.level;
	assign out.held_level  = res_q.held_level;
	assign out.changed     = res_q.changed;

	// Checks
	`TMDF_ASSERT_SAME(a_changed_takes_level, out.valid && out.changed, out.held_level == out.level, "held level differs from new level on a change")
	`TMDF_ASSERT_NEXT(a_burst_close_loads_s2, mv1 && burst_last, v2_q, "closing sample did not reach the divide stage")
	`TMDF_ASSERT_NEXT(a_bad_channel_dropped, acc && ({2'b00, in.channel} >= CH_LIM), !v1_q, "sample with channel out of range was kept")

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	import tmdf_pkg::*;

	localparam int CHANNELS = 5;
	localparam int SAMPLES = 7;
	localparam int NUM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int NUM_DIR = 24;

	// Directed stimulus row; want is only used where typed is set
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [SMP_W-1:0] smp;
		logic             typed;
		tmdf_res_t        want;
	} dir_row_t;

	// Reset settings: limit 1000, offset 100, ceiling 500, deadband 3.
	// Burst on ch0 of zeros with a bogus ch7 beat inside; burst on ch1 at full
	// scale with ch5/ch6 beats inside (capped at the ceiling); mixed burst
	// hopping channels, closing on ch4.
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd7, 16'hFFFF,   1'b0, '0},
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd0, 16'd0,      1'b0, '0},
		'{3'd0, 16'd0,      1'b1, '{3'd0, 10'd0, 10'd0, 1'b0}},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd5, 16'd0,      1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd6, 16'd1234,   1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b0, '0},
		'{3'd1, 16'hFFFF,   1'b1, '{3'd1, 10'd500, 10'd500, 1'b1}},
		'{3'd2, 16'd1000,   1'b0, '0},
		'{3'd3, 16'd999,    1'b0, '0},
		'{3'd4, 16'd0,      1'b0, '0},
		'{3'd2, 16'd500,    1'b0, '0},
		'{3'd3, 16'hFFFF,   1'b0, '0},
		'{3'd2, 16'd250,    1'b0, '0},
		'{3'd4, 16'd700,    1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [SMP_W-1:0]  cfg_wdata;

	tmdf_in_if  smp_if ();
	tmdf_out_if res_if ();

	trimmed_mean_deadband_filter_unit #(
		.CHANNELS(CHANNELS),
		.SAMPLES (SAMPLES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in       (smp_if.sink),
		.out      (res_if.source)
	);

	// Predictor state: settings shadow, burst accumulator, held levels
	tmdf_cfg_t        cfg_now;
	int unsigned      acc_sum;
	logic [SMP_W-1:0] acc_min;
	logic [SMP_W-1:0] acc_max;
	int unsigned      acc_cnt;
	logic [LVL_W-1:0] hold_tab [CHANNELS];

	tmdf_res_t exp_levels [$];
	int        fault_cnt;
	bit        idle_on;
	int        stall_left;

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

	// Trimmed mean, offset, ceiling and deadband hold for one kept sample
	function automatic bit predict_level(input logic [CH_W-1:0] ch,
			input logic [SMP_W-1:0] raw, output tmdf_res_t res);
		logic [SMP_W-1:0] s;
		int unsigned      mean;
		int unsigned      lvl;
		int unsigned      diff;
		res = '0;
		if (ch >= CHANNELS) return 1'b0;
		s = (raw > cfg_now.distance_limit) ? cfg_now.distance_limit : raw;
		acc_sum += s;
		if (s < acc_min) acc_min = s;
		if (s > acc_max) acc_max = s;
		acc_cnt++;
		if (acc_cnt < SAMPLES) return 1'b0;
		mean = (acc_sum - acc_min - acc_max) / (SAMPLES - 2);
		acc_sum = 0;
		acc_min = '1;
		acc_max = '0;
		acc_cnt = 0;
		lvl = (mean > cfg_now.level_offset) ? mean - cfg_now.level_offset : 0;
		if (lvl > cfg_now.level_ceiling) lvl = cfg_now.level_ceiling;
		diff = (hold_tab[ch] > lvl) ? hold_tab[ch] - lvl : lvl - hold_tab[ch];
		res.out_channel = ch;
		res.level = lvl[LVL_W-1:0];
		res.changed = (diff > cfg_now.deadband);
		if (res.changed) hold_tab[ch] = lvl[LVL_W-1:0];
		res.held_level = hold_tab[ch];
		return 1'b1;
	endfunction

	function automatic void note_fault(input string what, input tmdf_res_t want,
			input tmdf_res_t got);
		fault_cnt++;
		if (fault_cnt <= 10) begin
			$write("%s: want ch=%0d level=%0d held=%0d chg=%0b, ",
				what, want.out_channel, want.level, want.held_level, want.changed);
			$display("got ch=%0d level=%0d held=%0d chg=%0b",
				got.out_channel, got.level, got.held_level, got.changed);
		end
	endfunction

	// One sample beat, with an optional gap in front; predicts once accepted
	task automatic drive_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
			input bit typed, input tmdf_res_t want);
		int        gap;
		tmdf_res_t res;
		@(negedge clk);
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap != 0) begin
			smp_if.valid <= 1'b0;
			smp_if.channel <= CH_W'($urandom);
			smp_if.sample <= SMP_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.channel <= ch;
		smp_if.sample <= smp;
		do @(posedge clk); while (!smp_if.ready);
		if (predict_level(ch, smp, res)) exp_levels.push_back(typed ? want : res);
	endtask

	// Stop sending, wait for every pending result, then let the pipe empty
	task automatic drain(input int tail);
		@(negedge clk);
		smp_if.valid <= 1'b0;
		while (exp_levels.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [SMP_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DISTANCE_LIMIT: cfg_now.distance_limit = data;
			REG_LEVEL_OFFSET:   cfg_now.level_offset = data[LVL_W-1:0];
			REG_LEVEL_CEILING:  cfg_now.level_ceiling = data[LVL_W-1:0];
			REG_DEADBAND:       cfg_now.deadband = data[LVL_W-1:0];
			default: ;
		endcase
	endtask

	// Result side back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 7);
		if (stall_left != 0) begin
			res_if.ready <= 1'b0;
			stall_left--;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Result beat check against the oldest pending expectation
	always @(posedge clk) begin : res_check
		tmdf_res_t got;
		tmdf_res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.out_channel = res_if.out_channel;
			got.level = res_if.level;
			got.held_level = res_if.held_level;
			got.changed = res_if.changed;
			if (exp_levels.size() == 0) begin
				note_fault("unexpected result beat", '0, got);
			end else begin
				want = exp_levels.pop_front();
				if (got.out_channel !== want.out_channel || got.level !== want.level ||
						got.held_level !== want.held_level || got.changed !== want.changed)
					note_fault("result mismatch", want, got);
			end
		end
	end

	initial begin : stim
		logic [CH_W-1:0]  ch;
		logic [SMP_W-1:0] smp;
		logic [CH_W-1:0]  burst_ch;
		int unsigned      centre [CHANNELS];
		int               spread;
		int               sent;
		int               r;
		int               v;
		logic [SMP_W-1:0] lim;
		logic [LVL_W-1:0] off;
		logic [LVL_W-1:0] ceil_v;
		logic [LVL_W-1:0] db;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DISTANCE_LIMIT;
		cfg_wdata = '0;
		smp_if.valid = 1'b0;
		smp_if.channel = '0;
		smp_if.sample = '0;
		res_if.ready = 1'b0;
		stall_left = 0;
		fault_cnt = 0;
		idle_on = 1'b1;
		cfg_now = '{RST_DISTANCE_LIMIT, RST_LEVEL_OFFSET, RST_LEVEL_CEILING, RST_DEADBAND};
		acc_sum = 0;
		acc_min = '1;
		acc_max = '0;
		acc_cnt = 0;
		for (int i = 0; i < CHANNELS; i++) begin
			hold_tab[i] = '0;
			centre[i] = 0;
		end
		burst_ch = '0;
		spread = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset settings
		for (int i = 0; i < NUM_DIR; i++)
			drive_sample(DIR_ROWS[i].ch, DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		// Random part: phase 0 keeps the reset settings, the first few after it
		// hit the extremes, the rest are random
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase != 0) begin
				drain(10);
				case (phase)
					1: begin
						lim = 16'hFFFF; off = '0; ceil_v = '1; db = '0;
					end
					2: begin
						lim = '0; off = '1; ceil_v = '0; db = '1;
					end
					3: begin
						lim = 16'd1000; off = 10'd1000; ceil_v = 10'd1000; db = 10'd1000;
					end
					default: begin
						lim = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
							16'($urandom_range(200, 1600));
						off = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
							10'($urandom_range(0, 300));
						ceil_v = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
							10'($urandom_range(100, 1000));
						db = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
							10'($urandom_range(0, 20));
					end
				endcase
				// upper data bits of the narrow registers carry junk
				write_reg(REG_DISTANCE_LIMIT, lim);
				write_reg(REG_LEVEL_OFFSET, {6'($urandom), off});
				write_reg(REG_LEVEL_CEILING, {6'($urandom), ceil_v});
				write_reg(REG_DEADBAND, {6'($urandom), db});
			end
			idle_on = (phase < NUM_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// new burst: pick its channel, and either keep the level or move it
				if (acc_cnt == 0) begin
					burst_ch = CH_W'($urandom_range(0, CHANNELS - 1));
					if ($urandom_range(0, 1) == 0)
						centre[burst_ch] = ($urandom_range(0, 7) == 0) ?
							$urandom_range(0, 16'hFFFF) : $urandom_range(0, 1600);
					spread = $urandom_range(0, 12);
				end
				r = $urandom_range(0, 15);
				if (r == 0) begin
					// beat on a channel that does not exist
					drive_sample(3'($urandom_range(CHANNELS, 7)), 16'($urandom), 1'b0, '0);
				end else begin
					ch = (r == 1) ? 3'($urandom_range(0, CHANNELS - 1)) : burst_ch;
					if (r == 2) begin
						smp = 16'($urandom);
					end else begin
						v = int'(centre[burst_ch]) + int'($urandom_range(0, 2 * spread)) - spread;
						if (v < 0) v = 0;
						if (v > 65535) v = 65535;
						smp = 16'(v);
					end
					drive_sample(ch, smp, 1'b0, '0);
					sent++;
				end
			end
		end

		drain(20);
		if (fault_cnt == 0 && exp_levels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- trimmed_mean_deadband_filter_unit.f -----
+incdir+design
design/tmdf_pkg.sv
design/tmdf_ifs.sv
design/tmdf_burst.sv
design/tmdf_div.sv
design/tmdf_hold.sv
design/trimmed_mean_deadband_filter_unit.sv
verif/tb_top.sv
